>>> design/mcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcd_pkg
// Shared types, field widths, register indexes and reset values for the
// min/max column decimator.
// ----------------------------------------------------------------------------
package mcd_pkg;

    localparam int DEF_MAX_POINTS  = 16384;
    localparam int DEF_MAX_COLUMNS = 1024;

    localparam int NP_W       = 15;
    localparam int DC_W       = 10;
    localparam int PH_W       = 8;
    localparam int VS_W       = 8;
    localparam int SAMPLE_W   = 8;
    localparam int COLUMN_W   = 10;
    localparam int ROW_W      = 8;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 2;

    // Depth of the job queue between front and back.
    localparam int JOB_DEPTH = 2;

    localparam logic [NP_W-1:0] NUM_POINTS_RST    = 15'd1024;
    localparam logic [DC_W-1:0] DRAWN_COLUMNS_RST = 10'd278;
    localparam logic [PH_W-1:0] PANEL_HEIGHT_RST  = 8'd18;
    localparam logic [VS_W-1:0] VALUE_SPAN_RST    = 8'd255;

    localparam logic [SAMPLE_W-1:0] RUN_MIN_RST = 8'd255;
    localparam logic [SAMPLE_W-1:0] RUN_MAX_RST = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_POINTS    = 2'd0,
        CFG_DRAWN_COLUMNS = 2'd1,
        CFG_PANEL_HEIGHT  = 2'd2,
        CFG_VALUE_SPAN    = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [NP_W-1:0] num_points;
        logic [DC_W-1:0] drawn_columns;
        logic [PH_W-1:0] panel_height;
        logic [VS_W-1:0] value_span;
    } t_cfg;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                record_start;
    } t_in_word;

    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row_from_min;
        logic [ROW_W-1:0]    row_from_max;
        logic                last_column;
        logic                config_error;
    } t_out_word;

    // One classified result waiting for row scaling.
    typedef struct packed {
        logic                is_error;
        logic [COLUMN_W-1:0] column;
        logic                last_column;
        logic [SAMPLE_W-1:0] vmin;
        logic [SAMPLE_W-1:0] vmax;
    } t_job;

endpackage

>>> design/mcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcd_front
// Accepts samples, tracks the record position and the running min/max, and
// decides when an interval closes. Closed intervals and configuration errors
// are pushed as jobs into the queue.
// ----------------------------------------------------------------------------
module mcd_front #(
    parameter int MAX_POINTS  = mcd_pkg::DEF_MAX_POINTS,
    parameter int MAX_COLUMNS = mcd_pkg::DEF_MAX_COLUMNS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mcd_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  mcd_pkg::t_in_word i_in,
    output logic             o_push,
    output mcd_pkg::t_job    o_job,
    input  logic             i_full
);
    import mcd_pkg::*;

    localparam int SW = $clog2(MAX_POINTS);
    localparam int LW = SW + 1;
    localparam int CW = $clog2(MAX_COLUMNS);
    localparam int NW = CW + 1;
    localparam int PW = LW + NW;
    localparam int KW = PW + 2;

    localparam logic [SW-1:0] SI_MAX   = SW'(MAX_POINTS - 1);
    localparam logic [LW-1:0] LEN_MAX  = LW'(MAX_POINTS);
    localparam logic [CW-1:0] COLS_MAX = CW'(MAX_COLUMNS - 1);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_DEC  = 3'b100
    } t_fstate;

    t_fstate             r_state, n_state;
    logic [SW-1:0]       r_si, n_si;
    logic [CW-1:0]       r_col, n_col;
    logic [SAMPLE_W-1:0] r_min, n_min;
    logic [SAMPLE_W-1:0] r_max, n_max;
    logic [SAMPLE_W-1:0] r_sample, n_sample;
    logic [PW-1:0]       r_prod_a, n_prod_a;
    logic [PW-1:0]       r_prod_b, n_prod_b;

    logic [LW-1:0]       len;
    logic [CW-1:0]       cols;
    logic [NW-1:0]       n_cnt;
    logic [NW-1:0]       col_p1;
    logic [LW-1:0]       si_p2;
    logic [KW-1:0]       lhs;
    logic [KW-1:0]       rhs;
    logic                err_cfg;
    logic                need_push;
    logic [SAMPLE_W-1:0] v_min;
    logic [SAMPLE_W-1:0] v_max;
    logic [CW-1:0]       upd_col;
    logic [SAMPLE_W-1:0] upd_min;
    logic [SAMPLE_W-1:0] upd_max;
    t_job                job;

    always_comb begin
        if (32'(i_cfg.num_points) > 32'(MAX_POINTS)) begin
            len = LEN_MAX;
        end else begin
            len = LW'(i_cfg.num_points);
        end
        if (32'(i_cfg.drawn_columns) > 32'(MAX_COLUMNS - 1)) begin
            cols = COLS_MAX;
        end else begin
            cols = CW'(i_cfg.drawn_columns);
        end
    end

    assign n_cnt   = {1'b0, cols} + NW'(1);
    assign col_p1  = {1'b0, r_col} + NW'(1);
    assign si_p2   = {1'b0, r_si} + LW'(2);
    assign err_cfg = (32'(len) <= 32'(cols));

    // Interval closes when 2*(col+1)*num + n < 2*(si+2)*n, with n = drawn columns + 1.
    assign lhs = KW'({r_prod_a, 1'b0}) + KW'(n_cnt);
    assign rhs = KW'({r_prod_b, 1'b0});

    assign o_ready = (r_state == F_IDLE);

    always_comb begin
        n_state   = r_state;
        n_si      = r_si;
        n_col     = r_col;
        n_min     = r_min;
        n_max     = r_max;
        n_sample  = r_sample;
        n_prod_a  = r_prod_a;
        n_prod_b  = r_prod_b;
        need_push = 1'b0;
        job       = '0;
        v_min     = (r_sample < r_min) ? r_sample : r_min;
        v_max     = (r_sample > r_max) ? r_sample : r_max;
        upd_col   = r_col;
        upd_min   = r_min;
        upd_max   = r_max;
        o_push    = 1'b0;

        if (err_cfg) begin
            if (r_si == '0) begin
                need_push    = 1'b1;
                job.is_error = 1'b1;
            end
        end else if (32'(r_col) < 32'(cols)) begin
            if (lhs < rhs) begin
                need_push       = 1'b1;
                job.column      = COLUMN_W'(r_col);
                job.last_column = (col_p1 == {1'b0, cols});
                job.vmin        = v_min;
                job.vmax        = v_max;
                upd_col         = CW'(col_p1);
                upd_min         = RUN_MIN_RST;
                upd_max         = RUN_MAX_RST;
            end else begin
                upd_min = v_min;
                upd_max = v_max;
            end
        end

        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state  = F_MUL;
                    n_sample = i_in.sample;
                    if (i_in.record_start) begin
                        n_si  = '0;
                        n_col = '0;
                        n_min = RUN_MIN_RST;
                        n_max = RUN_MAX_RST;
                    end
                end
            end
            F_MUL: begin
                n_prod_a = PW'(col_p1) * PW'(len);
                n_prod_b = PW'(si_p2) * PW'(n_cnt);
                n_state  = F_DEC;
            end
            F_DEC: begin
                // State commits only once the job, if any, has a slot.
                if (!(need_push && i_full)) begin
                    o_push  = need_push;
                    n_col   = upd_col;
                    n_min   = upd_min;
                    n_max   = upd_max;
                    n_si    = (r_si < SI_MAX) ? (r_si + SW'(1)) : r_si;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    assign o_job = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_si    <= '0;
            r_col   <= '0;
            r_min   <= RUN_MIN_RST;
            r_max   <= RUN_MAX_RST;
        end else begin
            r_state <= n_state;
            r_si    <= n_si;
            r_col   <= n_col;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_prod_a <= n_prod_a;
        r_prod_b <= n_prod_b;
    end

endmodule

>>> design/mcd_job_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcd_job_fifo
// Short queue of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module mcd_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mcd_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output mcd_pkg::t_job o_job
);
    import mcd_pkg::*;

    localparam int PTR_W = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int CNT_W = $clog2(JOB_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(JOB_DEPTH - 1);

    t_job             r_mem [JOB_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(JOB_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : (r_wr_ptr + PTR_W'(1));
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : (r_rd_ptr + PTR_W'(1));
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

>>> design/mcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcd_back
// Scales the min and max of each column job to screen rows with one shared
// restoring divider and holds the finished word in the output register.
// ----------------------------------------------------------------------------
module mcd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mcd_pkg::t_cfg      i_cfg,
    input  logic               i_empty,
    output logic               o_pop,
    input  mcd_pkg::t_job      i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output mcd_pkg::t_out_word o_out
);
    import mcd_pkg::*;

    localparam int NUM_W = 2 * SAMPLE_W + 1;
    localparam int DEN_W = VS_W + 1;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_PREP = 5'b00010,
        B_SAT  = 5'b00100,
        B_DIV  = 5'b01000,
        B_OUT  = 5'b10000
    } t_bstate;

    t_bstate          r_state, n_state;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out, n_out;
    t_job             r_job, n_job;
    logic             r_sel_max, n_sel_max;
    logic [NUM_W-1:0] r_num, n_num;
    logic [NUM_W-1:0] r_hd, n_hd;
    logic [DEN_W-1:0] r_den, n_den;
    logic [NUM_W-1:0] r_rem, n_rem;
    logic [ROW_W-1:0] r_quo, n_quo;
    logic [2:0]       r_step, n_step;
    logic             r_sat, n_sat;
    logic [ROW_W-1:0] r_row_min, n_row_min;
    logic [ROW_W-1:0] r_row_max, n_row_max;

    logic [VS_W-1:0]         span;
    logic [DEN_W-1:0]        den_c;
    logic [SAMPLE_W-1:0]     v_sel;
    logic [2*SAMPLE_W-1:0]   vh;
    logic [NUM_W-1:0]        trial;
    logic [ROW_W-1:0]        quo_c;
    logic [ROW_W-1:0]        row_c;

    assign span  = (i_cfg.value_span == '0) ? VS_W'(1) : i_cfg.value_span;
    assign den_c = {span, 1'b0};
    assign v_sel = r_sel_max ? r_job.vmax : r_job.vmin;
    assign vh    = (2*SAMPLE_W)'(v_sel) * (2*SAMPLE_W)'(i_cfg.panel_height);
    assign trial = NUM_W'(r_den) << r_step;

    always_comb begin
        quo_c = r_quo;
        if (r_rem >= trial) begin
            quo_c[r_step] = 1'b1;
        end
        // A quotient at or above the height saturates the row to the top.
        row_c = r_sat ? '0 : (i_cfg.panel_height - quo_c);
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_job       = r_job;
        n_sel_max   = r_sel_max;
        n_num       = r_num;
        n_hd        = r_hd;
        n_den       = r_den;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_step      = r_step;
        n_sat       = r_sat;
        n_row_min   = r_row_min;
        n_row_max   = r_row_max;
        o_pop       = 1'b0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop     = 1'b1;
                    n_job     = i_job;
                    n_sel_max = 1'b0;
                    n_state   = i_job.is_error ? B_OUT : B_PREP;
                end
            end
            B_PREP: begin
                n_num   = {vh, 1'b0} + NUM_W'(span);
                n_den   = den_c;
                n_hd    = NUM_W'(i_cfg.panel_height) * NUM_W'(den_c);
                n_state = B_SAT;
            end
            B_SAT: begin
                n_sat   = (r_num >= r_hd);
                n_rem   = r_num;
                n_quo   = '0;
                n_step  = 3'd7;
                n_state = B_DIV;
            end
            B_DIV: begin
                if (r_rem >= trial) begin
                    n_rem = r_rem - trial;
                end
                n_quo = quo_c;
                if (r_step == 3'd0) begin
                    if (r_sel_max) begin
                        n_row_max = row_c;
                        n_state   = B_OUT;
                    end else begin
                        n_row_min = row_c;
                        n_sel_max = 1'b1;
                        n_state   = B_PREP;
                    end
                end else begin
                    n_step = r_step - 3'd1;
                end
            end
            B_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    if (r_job.is_error) begin
                        n_out              = '0;
                        n_out.config_error = 1'b1;
                    end else begin
                        n_out.column       = r_job.column;
                        n_out.row_from_min = r_row_min;
                        n_out.row_from_max = r_row_max;
                        n_out.last_column  = r_job.last_column;
                        n_out.config_error = 1'b0;
                    end
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out     <= n_out;
        r_job     <= n_job;
        r_sel_max <= n_sel_max;
        r_num     <= n_num;
        r_hd      <= n_hd;
        r_den     <= n_den;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_step    <= n_step;
        r_sat     <= n_sat;
        r_row_min <= n_row_min;
        r_row_max <= n_row_max;
    end

endmodule

>>> design/minmax_column_decimator.sv
`timescale 1ns / 1ps
// The front end takes each sample word through accept, boundary multiply and compare
// and accepts no new word until it is done with the last one.
// The back end handles a column word as pop, two row scalings and output; when columns
// close faster than the back end drains them, the queue fills and the input stalls.
// Reset (synchronous, active low) restores register defaults and starts a new record.
// ----------------------------------------------------------------------------
// minmax_column_decimator
// Min/max peak-detect decimation of a sample record into display columns.
// ----------------------------------------------------------------------------
module minmax_column_decimator #(
    parameter int MAX_POINTS  = mcd_pkg::DEF_MAX_POINTS,
    parameter int MAX_COLUMNS = mcd_pkg::DEF_MAX_COLUMNS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mcd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mcd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  mcd_pkg::t_in_word                 i_in,
    output logic                              o_valid,
    input  logic                              i_ready,
    output mcd_pkg::t_out_word                o_out
);
    import mcd_pkg::*;

    t_cfg r_cfg;
    logic fifo_push;
    logic fifo_full;
    logic fifo_pop;
    logic fifo_empty;
    t_job push_job;
    t_job pop_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_points    <= NUM_POINTS_RST;
            r_cfg.drawn_columns <= DRAWN_COLUMNS_RST;
            r_cfg.panel_height  <= PANEL_HEIGHT_RST;
            r_cfg.value_span    <= VALUE_SPAN_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_NUM_POINTS:    r_cfg.num_points    <= i_cfg_data[NP_W-1:0];
                CFG_DRAWN_COLUMNS: r_cfg.drawn_columns <= i_cfg_data[DC_W-1:0];
                CFG_PANEL_HEIGHT:  r_cfg.panel_height  <= i_cfg_data[PH_W-1:0];
                CFG_VALUE_SPAN:    r_cfg.value_span    <= i_cfg_data[VS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    mcd_front #(
        .MAX_POINTS  (MAX_POINTS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_push  (fifo_push),
        .o_job   (push_job),
        .i_full  (fifo_full)
    );

    mcd_job_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fifo_push),
        .i_job   (push_job),
        .o_full  (fifo_full),
        .i_pop   (fifo_pop),
        .o_empty (fifo_empty),
        .o_job   (pop_job)
    );

    mcd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_empty (fifo_empty),
        .o_pop   (fifo_pop),
        .i_job   (pop_job),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

endmodule
